/* rtl/lif_neuron_adaptive_threshold_step_defines.svh */
`ifndef LIF_NEURON_ADAPTIVE_THRESHOLD_STEP_DEFINES_SVH
`define LIF_NEURON_ADAPTIVE_THRESHOLD_STEP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LIFAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LIFAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lifat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lifat_pkg;

  typedef enum logic [2:0] {
    REG_THRESHOLD_BASE   = 3'd0,
    REG_REST_POTENTIAL   = 3'd1,
    REG_LEAK_FACTOR      = 3'd2,
    REG_SPIKE_DECAY      = 3'd3,
    REG_THRESHOLD_JUMP   = 3'd4,
    REG_RESET_SLOPE      = 3'd5,
    REG_RESET_OFFSET     = 3'd6,
    REG_REFRACTORY_STEPS = 3'd7
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;

  localparam logic signed [31:0] THRESHOLD_BASE_RST   = 32'sd26500000;
  localparam logic signed [31:0] REST_POTENTIAL_RST   = -32'sd77400000;
  localparam logic        [16:0] LEAK_FACTOR_RST      = 17'd0;
  localparam logic        [16:0] SPIKE_DECAY_RST      = 17'd65536;
  localparam logic signed [31:0] THRESHOLD_JUMP_RST   = 32'sd0;
  localparam logic signed [17:0] RESET_SLOPE_RST      = 18'sd0;
  localparam logic signed [31:0] RESET_OFFSET_RST     = 32'sd0;
  localparam logic        [15:0] REFRACTORY_STEPS_RST = 16'd1;

  typedef struct packed {
    logic signed [31:0] threshold_base;
    logic signed [31:0] rest_potential;
    logic        [16:0] leak_factor;
    logic        [16:0] spike_decay;
    logic signed [31:0] threshold_jump;
    logic signed [17:0] reset_slope;
    logic signed [31:0] reset_offset;
    logic        [15:0] refractory_steps;
  } cfg_t;

  typedef struct packed {
    logic               spike;
    logic signed [31:0] membrane_voltage;
    logic signed [31:0] firing_threshold;
    logic               refractory;
  } result_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sh00_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -40'sh00_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Q16 product back to integer, round half up (floor of p + 0.5)
  function automatic logic signed [35:0] rnd_q16(input logic signed [51:0] p);
    logic signed [51:0] t;
    t = p + 52'sd32768;
    return t[51:16];
  endfunction

endpackage

`default_nettype wire

/* rtl/lif_neuron_adaptive_threshold_step.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_current_step
// out       output     out_valid/out_stall out_spike, out_membrane_voltage,
//                                          out_firing_threshold, out_refractory
// config    input      psel/penable/pready paddr, pwrite, pwdata, prdata
//
// One neuron tick per beat; a beat can be accepted every cycle while in_stall is low.
// Each result is registered in the output register, or the second entry on out_stall.
// A two-entry output buffer absorbs one beat of out_stall; input stalls only
// while its second entry is full.
// Synchronous active-low reset clears the neuron state and loads register defaults.

`include "lif_neuron_adaptive_threshold_step_defines.svh"

module lif_neuron_adaptive_threshold_step (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic signed [31:0]               in_current_step,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic                             out_spike,
  output      logic signed [31:0]               out_membrane_voltage,
  output      logic signed [31:0]               out_firing_threshold,
  output      logic                             out_refractory,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lifat_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                      pwdata,
  output      logic [31:0]                      prdata,
  output      logic                             pready
);
  import lifat_pkg::*;

  cfg_t      cfg_r;
  result_t   res;
  result_t   out_r;
  result_t   skid_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      accept;
  logic      out_take;
  logic      cfg_wr;
  reg_idx_t  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_base   <= THRESHOLD_BASE_RST;
      cfg_r.rest_potential   <= REST_POTENTIAL_RST;
      cfg_r.leak_factor      <= LEAK_FACTOR_RST;
      cfg_r.spike_decay      <= SPIKE_DECAY_RST;
      cfg_r.threshold_jump   <= THRESHOLD_JUMP_RST;
      cfg_r.reset_slope      <= RESET_SLOPE_RST;
      cfg_r.reset_offset     <= RESET_OFFSET_RST;
      cfg_r.refractory_steps <= REFRACTORY_STEPS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_THRESHOLD_BASE:   cfg_r.threshold_base   <= pwdata;
        REG_REST_POTENTIAL:   cfg_r.rest_potential   <= pwdata;
        REG_LEAK_FACTOR:      cfg_r.leak_factor      <= pwdata[16:0];
        REG_SPIKE_DECAY:      cfg_r.spike_decay      <= pwdata[16:0];
        REG_THRESHOLD_JUMP:   cfg_r.threshold_jump   <= pwdata;
        REG_RESET_SLOPE:      cfg_r.reset_slope      <= pwdata[17:0];
        REG_RESET_OFFSET:     cfg_r.reset_offset     <= pwdata;
        REG_REFRACTORY_STEPS: cfg_r.refractory_steps <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD_BASE:   prdata = cfg_r.threshold_base;
      REG_REST_POTENTIAL:   prdata = cfg_r.rest_potential;
      REG_LEAK_FACTOR:      prdata = {15'd0, cfg_r.leak_factor};
      REG_SPIKE_DECAY:      prdata = {15'd0, cfg_r.spike_decay};
      REG_THRESHOLD_JUMP:   prdata = cfg_r.threshold_jump;
      REG_RESET_SLOPE:      prdata = {{14{cfg_r.reset_slope[17]}}, cfg_r.reset_slope};
      REG_RESET_OFFSET:     prdata = cfg_r.reset_offset;
      REG_REFRACTORY_STEPS: prdata = {16'd0, cfg_r.refractory_steps};
      default:              prdata = '0;
    endcase
  end

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  lifat_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (accept),
    .current_step (in_current_step),
    .cfg          (cfg_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_spike            = out_r.spike;
  assign out_membrane_voltage = out_r.membrane_voltage;
  assign out_firing_threshold = out_r.firing_threshold;
  assign out_refractory       = out_r.refractory;

  `LIFAT_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
    "second buffer entry full while output register empty")
  `LIFAT_ASSERT_NEXT(a_stalled_beat_parks, accept && out_valid_r && out_stall, skid_valid_r,
    "beat accepted under out_stall was not parked")
  `LIFAT_ASSERT_NEXT(a_drain_empties, out_take && !skid_valid_r && !accept, !out_valid_r,
    "output register still valid after its beat left")

endmodule

`default_nettype wire

/* rtl/lifat_core.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "lif_neuron_adaptive_threshold_step_defines.svh"

module lifat_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire logic signed [31:0] current_step,
  input  wire lifat_pkg::cfg_t    cfg,
  output      lifat_pkg::result_t res
);
  import lifat_pkg::*;

  logic signed [31:0] voltage_r, voltage_nxt;
  logic signed [31:0] pending_r, pending_nxt;
  logic signed [31:0] comp_r, comp_nxt;
  logic signed [31:0] thr_r, thr_nxt;
  logic        [16:0] left_r, left_nxt;

  logic signed [32:0] diff;
  logic signed [50:0] leak_prod;
  logic signed [35:0] leak_q;
  logic signed [39:0] integ;
  logic signed [31:0] v_int;
  logic signed [49:0] decay_prod;
  logic signed [35:0] decay_q;
  logic signed [31:0] comp_dec;
  logic signed [31:0] thr_int;
  logic               fire;
  logic        [16:0] left_dec;
  logic signed [49:0] slope_prod;
  logic signed [35:0] slope_q;
  logic signed [31:0] v_rst;
  logic signed [31:0] comp_jmp;
  logic signed [31:0] thr_jmp;

  always_comb begin
    diff       = {voltage_r[31], voltage_r} - {cfg.rest_potential[31], cfg.rest_potential};
    leak_prod  = diff * $signed({1'b0, cfg.leak_factor});
    leak_q     = rnd_q16({leak_prod[50], leak_prod});
    integ      = {{8{voltage_r[31]}}, voltage_r} + {{8{pending_r[31]}}, pending_r}
                 - {{4{leak_q[35]}}, leak_q};
    v_int      = sat32(integ);
    decay_prod = comp_r * $signed({1'b0, cfg.spike_decay});
    decay_q    = rnd_q16({{2{decay_prod[49]}}, decay_prod});
    comp_dec   = sat32({{4{decay_q[35]}}, decay_q});
    thr_int    = sat32({{8{comp_dec[31]}}, comp_dec}
                       + {{8{cfg.threshold_base[31]}}, cfg.threshold_base});
    fire       = v_int > thr_int;

    left_dec   = left_r - 17'd1;
    slope_prod = voltage_r * cfg.reset_slope;
    slope_q    = rnd_q16({{2{slope_prod[49]}}, slope_prod});
    v_rst      = sat32({{4{slope_q[35]}}, slope_q}
                       + {{8{cfg.reset_offset[31]}}, cfg.reset_offset});
    comp_jmp   = sat32({{8{comp_r[31]}}, comp_r}
                       + {{8{cfg.threshold_jump[31]}}, cfg.threshold_jump});
    thr_jmp    = sat32({{8{comp_jmp[31]}}, comp_jmp}
                       + {{8{cfg.threshold_base[31]}}, cfg.threshold_base});
  end

  always_comb begin
    voltage_nxt = voltage_r;
    comp_nxt    = comp_r;
    thr_nxt     = thr_r;
    left_nxt    = left_r;
    pending_nxt = current_step;
    if (left_r != 17'd0) begin
      left_nxt = left_dec;
      if (left_dec == 17'd0) begin
        voltage_nxt = v_rst;
        comp_nxt    = comp_jmp;
        thr_nxt     = thr_jmp;
      end
    end else begin
      voltage_nxt = v_int;
      comp_nxt    = comp_dec;
      thr_nxt     = thr_int;
      left_nxt    = fire ? ({1'b0, cfg.refractory_steps} + 17'd1) : 17'd0;
    end
  end

  always_comb begin
    res.spike            = fire && (left_r == 17'd0);
    res.membrane_voltage = voltage_nxt;
    res.firing_threshold = thr_nxt;
    res.refractory       = left_nxt != 17'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voltage_r <= '0;
      pending_r <= '0;
      comp_r    <= '0;
      thr_r     <= '0;
      left_r    <= '0;
    end else if (step_en) begin
      voltage_r <= voltage_nxt;
      pending_r <= pending_nxt;
      comp_r    <= comp_nxt;
      thr_r     <= thr_nxt;
      left_r    <= left_nxt;
    end
  end

  `LIFAT_ASSERT_NEXT(a_spike_loads_count, step_en && res.spike, left_r != 17'd0,
    "spike did not start the refractory countdown")
  `LIFAT_ASSERT_NOW(a_no_spike_in_refr, left_r != 17'd0, !res.spike,
    "spike raised during refractory")
  `LIFAT_ASSERT_NEXT(a_hold_when_idle, !step_en, $stable(voltage_r) && $stable(left_r),
    "neuron state moved without a beat")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lifat_pkg::*;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam int PHASES = 9;
  localparam int PHASE_BEATS = 192;
  localparam int REG_W [8] = '{32, 32, 17, 17, 32, 18, 32, 16};

  typedef struct {
    bit                 is_cfg;
    reg_idx_t           idx;
    logic        [31:0] data;
    logic signed [31:0] cur;
    bit                 typed;
    result_t            want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [31:0]      in_current_step = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_spike;
  logic signed [31:0]      out_membrane_voltage;
  logic signed [31:0]      out_firing_threshold;
  logic                    out_refractory;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  logic signed [31:0] thr_base_r, rest_r, jump_r, offset_r;
  logic        [16:0] leak_r, decay_r;
  logic signed [17:0] slope_r;
  logic        [15:0] refr_steps_r;
  logic signed [31:0] v_r, pend_r, comp_r, thr_r;
  logic        [16:0] refr_left_r;

  result_t predicted_ticks[$];
  int      mismatch_count = 0;
  bit      idle_on = 1'b1;
  bit      pressure_armed = 1'b0;

  lif_neuron_adaptive_threshold_step u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_current_step      (in_current_step),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_spike            (out_spike),
    .out_membrane_voltage (out_membrane_voltage),
    .out_firing_threshold (out_firing_threshold),
    .out_refractory       (out_refractory),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint q16_scale(longint a, longint f);
    longint p;
    p = a * f + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp_s32(longint x);
    if (x > longint'(S32_MAX)) return S32_MAX;
    if (x < longint'(S32_MIN)) return S32_MIN;
    return x[31:0];
  endfunction

  function automatic result_t neuron_tick(logic signed [31:0] cur);
    result_t r;
    longint  leak;
    r.spike = 1'b0;
    if (refr_left_r != 17'd0) begin
      refr_left_r = refr_left_r - 17'd1;
      if (refr_left_r == 17'd0) begin
        v_r = clamp_s32(q16_scale(longint'(v_r), longint'(slope_r)) + longint'(offset_r));
        comp_r = clamp_s32(longint'(comp_r) + longint'(jump_r));
        thr_r = clamp_s32(longint'(comp_r) + longint'(thr_base_r));
      end
    end else begin
      leak = q16_scale(longint'(v_r) - longint'(rest_r), longint'(leak_r));
      v_r = clamp_s32(longint'(v_r) + longint'(pend_r) - leak);
      comp_r = clamp_s32(q16_scale(longint'(comp_r), longint'(decay_r)));
      thr_r = clamp_s32(longint'(comp_r) + longint'(thr_base_r));
      if (v_r > thr_r) begin
        r.spike = 1'b1;
        refr_left_r = {1'b0, refr_steps_r} + 17'd1;
      end
    end
    pend_r = cur;
    r.membrane_voltage = v_r;
    r.firing_threshold = thr_r;
    r.refractory = (refr_left_r != 17'd0);
    return r;
  endfunction

  function automatic logic [31:0] pick_bits(int w);
    logic [31:0] mask;
    mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return mask;
      2: return 32'd1 << (w - 1);
      3: return (32'd1 << (w - 1)) - 32'd1;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic logic signed [31:0] draw_current(bit wild);
    case ($urandom_range(0, 31))
      0: return S32_MAX;
      1: return S32_MIN;
      2, 3: return $urandom;
      default: begin
        if (wild) return $urandom;
        return $signed($urandom_range(0, 9000000)) - 32'sd1500000;
      end
    endcase
  endfunction

  function automatic plan_row_t item_row(logic signed [31:0] cur);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_THRESHOLD_BASE;
    r.data = '0;
    r.cur = cur;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t checked_row(logic signed [31:0] cur, logic sp,
                                            logic signed [31:0] v, logic signed [31:0] thr,
                                            logic rf);
    plan_row_t r;
    r = item_row(cur);
    r.typed = 1'b1;
    r.want.spike = sp;
    r.want.membrane_voltage = v;
    r.want.firing_threshold = thr;
    r.want.refractory = rf;
    return r;
  endfunction

  function automatic plan_row_t reg_row(reg_idx_t idx, logic [31:0] data);
    plan_row_t r;
    r = item_row('0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_tick();
    result_t want;
    if (predicted_ticks.size() == 0) begin
      flag_mismatch("beat with no prediction", out_membrane_voltage, '0);
    end else begin
      want = predicted_ticks.pop_front();
      if (out_spike !== want.spike) begin
        flag_mismatch("spike", {31'd0, out_spike}, {31'd0, want.spike});
      end
      if (out_membrane_voltage !== want.membrane_voltage) begin
        flag_mismatch("membrane_voltage", out_membrane_voltage, want.membrane_voltage);
      end
      if (out_firing_threshold !== want.firing_threshold) begin
        flag_mismatch("firing_threshold", out_firing_threshold, want.firing_threshold);
      end
      if (out_refractory !== want.refractory) begin
        flag_mismatch("refractory", {31'd0, out_refractory}, {31'd0, want.refractory});
      end
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD_BASE:   thr_base_r = data;
      REG_REST_POTENTIAL:   rest_r = data;
      REG_LEAK_FACTOR:      leak_r = data[16:0];
      REG_SPIKE_DECAY:      decay_r = data[16:0];
      REG_THRESHOLD_JUMP:   jump_r = data;
      REG_RESET_SLOPE:      slope_r = data[17:0];
      REG_RESET_OFFSET:     offset_r = data;
      REG_REFRACTORY_STEPS: refr_steps_r = data[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (predicted_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic offer_beat(logic signed [31:0] cur, bit typed, result_t want);
    result_t p;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_current_step <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = neuron_tick(cur);
    predicted_ticks.push_back(typed ? want : p);
  endtask

  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_tick();
      if (hold > 0) begin
        hold--;
      end else if (pressure_armed) begin
        hold = 64;
        pressure_armed = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 11);
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    logic [31:0] vals [8];
    bit          wild;

    thr_base_r = THRESHOLD_BASE_RST;
    rest_r = REST_POTENTIAL_RST;
    leak_r = LEAK_FACTOR_RST;
    decay_r = SPIKE_DECAY_RST;
    jump_r = THRESHOLD_JUMP_RST;
    slope_r = RESET_SLOPE_RST;
    offset_r = RESET_OFFSET_RST;
    refr_steps_r = REFRACTORY_STEPS_RST;
    v_r = '0;
    pend_r = '0;
    comp_r = '0;
    thr_r = '0;
    refr_left_r = '0;

    plan.push_back(checked_row(32'sd0, 1'b0, 32'sd0, 32'sd26500000, 1'b0));
    plan.push_back(checked_row(S32_MAX, 1'b0, 32'sd0, 32'sd26500000, 1'b0));
    plan.push_back(checked_row(S32_MIN, 1'b1, S32_MAX, 32'sd26500000, 1'b1));
    plan.push_back(checked_row(32'sd0, 1'b0, S32_MAX, 32'sd26500000, 1'b1));
    plan.push_back(checked_row(32'sd0, 1'b0, 32'sd0, 32'sd26500000, 1'b0));
    plan.push_back(checked_row(S32_MIN, 1'b0, 32'sd0, 32'sd26500000, 1'b0));
    plan.push_back(checked_row(S32_MIN, 1'b0, S32_MIN, 32'sd26500000, 1'b0));
    plan.push_back(checked_row(32'sd0, 1'b0, S32_MIN, 32'sd26500000, 1'b0));

    plan.push_back(reg_row(REG_REFRACTORY_STEPS, 32'd0));
    plan.push_back(reg_row(REG_THRESHOLD_JUMP, S32_MAX));
    plan.push_back(reg_row(REG_RESET_SLOPE, 32'h0002_0000));
    plan.push_back(reg_row(REG_RESET_OFFSET, 32'd1000));
    plan.push_back(item_row(S32_MAX));
    plan.push_back(item_row(S32_MAX));
    plan.push_back(item_row(S32_MAX));
    plan.push_back(item_row(32'sd0));
    plan.push_back(item_row(32'sd0));
    plan.push_back(item_row(32'sd0));

    plan.push_back(reg_row(REG_SPIKE_DECAY, 32'd131071));
    plan.push_back(reg_row(REG_LEAK_FACTOR, 32'd131071));
    plan.push_back(reg_row(REG_THRESHOLD_BASE, S32_MIN));
    plan.push_back(reg_row(REG_REST_POTENTIAL, S32_MAX));
    plan.push_back(reg_row(REG_REFRACTORY_STEPS, 32'd3));
    plan.push_back(item_row(S32_MIN));
    plan.push_back(item_row(S32_MAX));
    plan.push_back(item_row(32'sd0));
    plan.push_back(item_row(-32'sd1));
    plan.push_back(item_row(32'sd1));
    plan.push_back(item_row(32'sh5555_5555));
    plan.push_back(item_row(32'shAAAA_AAAA));

    plan.push_back(reg_row(REG_LEAK_FACTOR, 32'd65536));
    plan.push_back(reg_row(REG_SPIKE_DECAY, 32'd0));
    plan.push_back(reg_row(REG_THRESHOLD_BASE, S32_MAX));
    plan.push_back(reg_row(REG_REST_POTENTIAL, S32_MIN));
    plan.push_back(reg_row(REG_RESET_SLOPE, 32'h0001_FFFF));
    plan.push_back(reg_row(REG_RESET_OFFSET, S32_MIN));
    plan.push_back(reg_row(REG_THRESHOLD_JUMP, S32_MIN));
    plan.push_back(reg_row(REG_REFRACTORY_STEPS, 32'd2));
    plan.push_back(item_row(32'sd12345));
    plan.push_back(item_row(-32'sd12345));
    plan.push_back(item_row(S32_MAX));
    plan.push_back(item_row(S32_MIN));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer_beat(plan[i].cur, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_idle();
      idle_on = (ph != PHASES - 1) && (ph % 4 != 3);
      wild = (ph % 3 == 1);
      if (wild) begin
        for (int r = 0; r < 8; r++) vals[r] = pick_bits(REG_W[r]);
        vals[REG_REFRACTORY_STEPS] = $urandom_range(0, 20);
      end else begin
        vals[REG_THRESHOLD_BASE] = $signed($urandom_range(0, 40000000)) - 32'sd20000000;
        vals[REG_REST_POTENTIAL] = 32'sd0 - $signed($urandom_range(0, 80000000));
        vals[REG_LEAK_FACTOR] = $urandom_range(0, 8000);
        vals[REG_SPIKE_DECAY] = $urandom_range(50000, 65536);
        vals[REG_THRESHOLD_JUMP] = $urandom_range(0, 20000000);
        vals[REG_RESET_SLOPE] = $urandom_range(0, 65536);
        vals[REG_RESET_OFFSET] = 32'sd0 - $signed($urandom_range(0, 60000000));
        vals[REG_REFRACTORY_STEPS] = $urandom_range(0, 6);
      end
      if (ph == PHASES - 1) vals[REG_REFRACTORY_STEPS] = 32'd65535;
      for (int r = 0; r < 8; r++) write_reg(reg_idx_t'(r), vals[r]);
      if (ph == 2) pressure_armed = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) offer_beat(draw_current(wild), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (predicted_ticks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
